FILE: design/qsg_pkg.sv
package qsg_pkg;

  localparam int IO_WIDTH = 32;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] node0_x;
    logic signed [IO_WIDTH-1:0] node0_y;
    logic signed [IO_WIDTH-1:0] node1_x;
    logic signed [IO_WIDTH-1:0] node1_y;
    logic signed [IO_WIDTH-1:0] node2_x;
    logic signed [IO_WIDTH-1:0] node2_y;
    logic signed [IO_WIDTH-1:0] node3_x;
    logic signed [IO_WIDTH-1:0] node3_y;
    logic                       final_element;
  } qsg_in_t;

  typedef struct packed {
    logic [1:0]                 gauss_point;
    logic signed [IO_WIDTH-1:0] grad0_x;
    logic signed [IO_WIDTH-1:0] grad0_y;
    logic signed [IO_WIDTH-1:0] grad1_x;
    logic signed [IO_WIDTH-1:0] grad1_y;
    logic signed [IO_WIDTH-1:0] grad2_x;
    logic signed [IO_WIDTH-1:0] grad2_y;
    logic signed [IO_WIDTH-1:0] grad3_x;
    logic signed [IO_WIDTH-1:0] grad3_y;
    logic signed [IO_WIDTH-1:0] point_volume;
    logic                       last_point;
    logic                       singular;
  } qsg_out_t;

  // Gauss point sequencing between the front end and the Jacobian stages
  typedef struct packed {
    logic       valid;
    logic [1:0] point;
  } qsg_pt_t;

  // Per-point status after the determinant
  typedef struct packed {
    logic       valid;
    logic [1:0] point;
    logic       singular;
  } qsg_ctl_t;

  localparam logic [1:0] LAST_POINT = 2'd3;

  // Local gradient codes: plus/minus A, plus/minus B
  localparam logic signed [2:0] CODE_PA = 3'sd1;
  localparam logic signed [2:0] CODE_NA = -3'sd1;
  localparam logic signed [2:0] CODE_PB = 3'sd2;
  localparam logic signed [2:0] CODE_NB = -3'sd2;

  // A = (1 + 1/sqrt3)/4 and B = (1 - 1/sqrt3)/4 at 32 fraction bits
  localparam longint unsigned CONST_A_Q32 = 64'd1693666955;
  localparam longint unsigned CONST_B_Q32 = 64'd453816693;

  // [point][node][direction]
  localparam logic signed [2:0] LG_TAB [4][4][2] = '{
    '{ '{CODE_NA, CODE_NA}, '{CODE_PA, CODE_NB}, '{CODE_PB, CODE_PB}, '{CODE_NB, CODE_PA} },
    '{ '{CODE_NA, CODE_NB}, '{CODE_PA, CODE_NA}, '{CODE_PB, CODE_PA}, '{CODE_NB, CODE_PB} },
    '{ '{CODE_NB, CODE_NB}, '{CODE_PB, CODE_NA}, '{CODE_PA, CODE_PA}, '{CODE_NA, CODE_PB} },
    '{ '{CODE_NB, CODE_NA}, '{CODE_PB, CODE_NB}, '{CODE_PA, CODE_PB}, '{CODE_NA, CODE_PA} }
  };

endpackage

FILE: design/qsg_front.sv
module qsg_front #(
  parameter int DW = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  qsg_pkg::qsg_in_t        in_data,
  output logic                    in_stall,
  output qsg_pkg::qsg_pt_t        pt,
  output logic signed [DW-1:0]    coord [8]
);
  import qsg_pkg::*;

  localparam int IW = (DW > IO_WIDTH) ? DW + 1 : IO_WIDTH + 1;
  localparam logic signed [IW-1:0] SMAX = {{(IW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [IW-1:0] SMIN = ~SMAX;

  logic                 busy_r, busy_nxt;
  logic [1:0]           pt_r, pt_nxt;
  logic signed [DW-1:0] crd_r [8];
  logic signed [DW-1:0] crd_nxt [8];
  logic signed [IO_WIDTH-1:0] raw [8];
  logic                 acc;

  assign raw[0] = in_data.node0_x;
  assign raw[1] = in_data.node0_y;
  assign raw[2] = in_data.node1_x;
  assign raw[3] = in_data.node1_y;
  assign raw[4] = in_data.node2_x;
  assign raw[5] = in_data.node2_y;
  assign raw[6] = in_data.node3_x;
  assign raw[7] = in_data.node3_y;

  // take a new element on the edge that issues the last point of the current one
  assign in_stall = !en || (busy_r && pt_r != LAST_POINT);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    logic signed [IW-1:0] w;
    for (int n = 0; n < 8; n++) begin
      w = IW'(raw[n]);
      if (w > SMAX) begin
        crd_nxt[n] = DW'(SMAX);
      end else if (w < SMIN) begin
        crd_nxt[n] = DW'(SMIN);
      end else begin
        crd_nxt[n] = DW'(w);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pt_nxt   = pt_r;
    if (en) begin
      if (acc) begin
        busy_nxt = 1'b1;
        pt_nxt   = '0;
      end else if (busy_r) begin
        busy_nxt = (pt_r != LAST_POINT);
        pt_nxt   = pt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pt_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pt_r   <= pt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      crd_r <= crd_nxt;
    end
  end

  assign pt.valid = busy_r;
  assign pt.point = pt_r;
  assign coord    = crd_r;

endmodule

FILE: design/qsg_jac.sv
module qsg_jac #(
  parameter int DW = 32,
  parameter int FB = 16,
  parameter int NW = DW + FB + 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  qsg_pkg::qsg_pt_t        pt,
  input  logic signed [DW-1:0]    coord [8],
  output qsg_pkg::qsg_ctl_t       ctl,
  output logic signed [DW-1:0]    det,
  output logic signed [NW-1:0]    num_x [4],
  output logic signed [NW-1:0]    num_y [4]
);
  import qsg_pkg::*;

  localparam int CW  = FB + 2;
  localparam int PW  = DW + CW;
  localparam int AW  = PW + 3;
  localparam int DPW = 2 * DW + 2;

  localparam longint unsigned CA_U = (CONST_A_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
  localparam longint unsigned CB_U = (CONST_B_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
  localparam logic signed [CW-1:0] COEF_A = CW'(CA_U);
  localparam logic signed [CW-1:0] COEF_B = CW'(CB_U);

  localparam logic signed [AW-1:0]  HALF_A = AW'(1) <<< (FB - 1);
  localparam logic signed [AW-1:0]  SMAX_A = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [DPW-1:0] HALF_D = DPW'(1) <<< (FB - 1);
  localparam logic signed [DPW-1:0] SMAX_D = {{(DPW-DW+1){1'b0}}, {(DW-1){1'b1}}};

  function automatic logic signed [CW-1:0] coef(input logic signed [2:0] code);
    logic signed [CW-1:0] r;
    case (code)
      CODE_PA: r = COEF_A;
      CODE_NA: r = -COEF_A;
      CODE_PB: r = COEF_B;
      CODE_NB: r = -COEF_B;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DW-1:0] rsat_a(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] s;
    s = (a + HALF_A) >>> FB;
    if (s > SMAX_A) begin
      return DW'(SMAX_A);
    end else if (s < ~SMAX_A) begin
      return DW'(~SMAX_A);
    end
    return DW'(s);
  endfunction

  function automatic logic signed [DW-1:0] rsat_d(input logic signed [DPW-1:0] a);
    logic signed [DPW-1:0] s;
    s = (a + HALF_D) >>> FB;
    if (s > SMAX_D) begin
      return DW'(SMAX_D);
    end else if (s < ~SMAX_D) begin
      return DW'(~SMAX_D);
    end
    return DW'(s);
  endfunction

  // stage 1: coefficient products
  logic                 s1_v_r;
  logic [1:0]           s1_pt_r;
  logic signed [CW-1:0] s1_c_r [4][2];
  logic signed [PW-1:0] s1_p_r [4][4];
  logic signed [CW-1:0] c_nxt [4][2];
  logic signed [PW-1:0] p_nxt [4][4];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 2; i++) begin
        c_nxt[m][i] = coef(LG_TAB[pt.point][m][i]);
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        for (int m = 0; m < 4; m++) begin
          p_nxt[i*2+j][m] = PW'(c_nxt[m][i]) * PW'(coord[m*2+j]);
        end
      end
    end
  end

  // stage 2: Jacobian entries, order J00 J01 J10 J11
  logic                 s2_v_r;
  logic [1:0]           s2_pt_r;
  logic signed [CW-1:0] s2_c_r [4][2];
  logic signed [DW-1:0] s2_j_r [4];
  logic signed [DW-1:0] j_nxt [4];

  always_comb begin
    logic signed [AW-1:0] a;
    for (int e = 0; e < 4; e++) begin
      a = AW'(s1_p_r[e][0]) + AW'(s1_p_r[e][1]) + AW'(s1_p_r[e][2]) + AW'(s1_p_r[e][3]);
      j_nxt[e] = rsat_a(a);
    end
  end

  // stage 3: determinant and adjugate products
  logic                  s3_v_r;
  logic [1:0]            s3_pt_r;
  logic signed [DPW-1:0] s3_d0_r, s3_d1_r;
  logic signed [PW-1:0]  s3_xa_r [4];
  logic signed [PW-1:0]  s3_xb_r [4];
  logic signed [PW-1:0]  s3_ya_r [4];
  logic signed [PW-1:0]  s3_yb_r [4];

  // stage 4 outputs
  logic                  s4_v_r;
  logic [1:0]            s4_pt_r;
  logic                  s4_sing_r;
  logic signed [DW-1:0]  s4_det_r;
  logic signed [NW-1:0]  s4_nx_r [4];
  logic signed [NW-1:0]  s4_ny_r [4];
  logic signed [DW-1:0]  det_nxt;

  assign det_nxt = rsat_d(s3_d0_r - s3_d1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= pt.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pt_r <= pt.point;
      s1_c_r  <= c_nxt;
      s1_p_r  <= p_nxt;

      s2_pt_r <= s1_pt_r;
      s2_c_r  <= s1_c_r;
      s2_j_r  <= j_nxt;

      s3_pt_r <= s2_pt_r;
      s3_d0_r <= DPW'(s2_j_r[0]) * DPW'(s2_j_r[3]);
      s3_d1_r <= DPW'(s2_j_r[1]) * DPW'(s2_j_r[2]);
      for (int m = 0; m < 4; m++) begin
        s3_xa_r[m] <= PW'(s2_j_r[3]) * PW'(s2_c_r[m][0]);
        s3_xb_r[m] <= PW'(s2_j_r[1]) * PW'(s2_c_r[m][1]);
        s3_ya_r[m] <= PW'(s2_j_r[2]) * PW'(s2_c_r[m][0]);
        s3_yb_r[m] <= PW'(s2_j_r[0]) * PW'(s2_c_r[m][1]);
      end

      s4_pt_r   <= s3_pt_r;
      s4_det_r  <= det_nxt;
      s4_sing_r <= (det_nxt == '0);
      for (int m = 0; m < 4; m++) begin
        s4_nx_r[m] <= NW'(s3_xa_r[m]) - NW'(s3_xb_r[m]);
        s4_ny_r[m] <= NW'(s3_yb_r[m]) - NW'(s3_ya_r[m]);
      end
    end
  end

  assign ctl.valid    = s4_v_r;
  assign ctl.point    = s4_pt_r;
  assign ctl.singular = s4_sing_r;
  assign det          = s4_det_r;
  assign num_x        = s4_nx_r;
  assign num_y        = s4_ny_r;

endmodule

FILE: design/qsg_div.sv
module qsg_div #(
  parameter int DW = 32,
  parameter int NW = 51
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic                 zero,
  output logic signed [DW-1:0] quo
);
  import qsg_pkg::*;

  localparam int QW = DW + 1;
  localparam int LW = NW + DW + 2;
  localparam int MW = DW + 2;
  localparam logic [MW-1:0] LIM_POS = MW'((MW'(1) << (DW - 1)) - MW'(1));
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (DW - 1);

  // magnitudes
  logic [NW-1:0] nm0_r;
  logic [DW-1:0] dm0_r;
  logic          neg0_r, zero0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nm0_r   <= num[NW-1] ? NW'(-num) : NW'(num);
      dm0_r   <= den[DW-1] ? DW'(-den) : DW'(den);
      neg0_r  <= num[NW-1] ^ den[DW-1];
      zero0_r <= zero;
    end
  end

  // restoring steps, one quotient bit per stage
  logic [NW-1:0] rem_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] dm_r  [QW+1];
  logic          neg_r [QW+1];
  logic          zr_r  [QW+1];
  logic          ovf_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nm0_r;
      q_r[0]   <= '0;
      dm_r[0]  <= dm0_r;
      neg_r[0] <= neg0_r;
      zr_r[0]  <= zero0_r;
      ovf_r[0] <= (LW'(nm0_r) >= (LW'(dm0_r) << QW));
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int P = DW - s;
    logic [LW-1:0] trial;
    logic          ge;

    assign trial = LW'(dm_r[s]) << P;
    assign ge    = (LW'(rem_r[s]) >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? NW'(LW'(rem_r[s]) - trial) : rem_r[s];
        q_r[s+1]   <= ge ? (q_r[s] | (QW'(1) << P)) : q_r[s];
        dm_r[s+1]  <= dm_r[s];
        neg_r[s+1] <= neg_r[s];
        zr_r[s+1]  <= zr_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  // round half away from zero, saturate, apply sign
  logic [MW-1:0]        mag, lim;
  logic signed [DW-1:0] res;
  logic signed [DW-1:0] quo_r;

  always_comb begin
    lim = neg_r[QW] ? LIM_NEG : LIM_POS;
    mag = MW'(q_r[QW]);
    if ((LW'(rem_r[QW]) << 1) >= LW'(dm_r[QW])) begin
      mag = mag + MW'(1);
    end
    if (ovf_r[QW] || mag > lim) begin
      mag = lim;
    end
    res = neg_r[QW] ? DW'(-mag) : DW'(mag);
    if (zr_r[QW]) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= res;
    end
  end

  assign quo = quo_r;

endmodule

FILE: design/quad4_shape_gradient_kernel.sv
// Bilinear four-node quad: Jacobian, determinant and global shape gradients
// at the four 2x2 Gauss points of each element.
// Input channel (in_valid / in_stall / in_data): one transaction carries the
// four corner coordinates of an element, signed Q16.16.
// Output channel (out_valid / out_stall / out_data): four transactions per
// element, Gauss points 0..3 in order, last_point set on the fourth. Each
// carries eight gradients, the point volume (det J) and a singular flag;
// a zero rounded determinant gives zero gradients and singular = 1.
// The front end issues one Gauss point per cycle from a held element unless
// the output stalls, and it takes the next element as it issues the last
// point of the current one. Most of the pipeline depth lies in the
// pipelined divider, which resolves one quotient bit per stage.
// Reset (rst_n low, synchronous) drops all work in flight and clears valids.
// A stall on the output freezes the whole pipeline in place; nothing is
// lost or repeated, and in_stall rises until the result is taken.
module quad4_shape_gradient_kernel #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qsg_pkg::qsg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qsg_pkg::qsg_out_t out_data
);
  import qsg_pkg::*;

  localparam int DW      = DATA_WIDTH;
  localparam int NW      = DATA_WIDTH + FRAC_BITS + 3;
  localparam int DIV_LAT = DATA_WIDTH + 4;

  // advance the whole pipeline unless a finished result is held under out_stall
  logic adv;
  logic out_valid_r;
  qsg_out_t out_data_r, out_data_nxt;

  assign adv = !out_valid_r || !out_stall;

  // front end: hold the element, issue one Gauss point per cycle unless stalled
  qsg_pt_t              pt;
  logic signed [DW-1:0] coord [8];

  qsg_front #(.DW(DW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .pt       (pt),
    .coord    (coord)
  );

  // Jacobian, determinant and adjugate numerators
  qsg_ctl_t             jctl;
  logic signed [DW-1:0] det;
  logic signed [NW-1:0] num_x [4];
  logic signed [NW-1:0] num_y [4];

  qsg_jac #(.DW(DW), .FB(FRAC_BITS), .NW(NW)) u_jac (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .pt    (pt),
    .coord (coord),
    .ctl   (jctl),
    .det   (det),
    .num_x (num_x),
    .num_y (num_y)
  );

  // eight divider lanes: x then y gradient for each node
  logic signed [DW-1:0] grad [8];

  for (genvar g = 0; g < 8; g++) begin : g_lane
    qsg_div #(.DW(DW), .NW(NW)) u_div (
      .clk  (clk),
      .en   (adv),
      .num  ((g % 2 == 0) ? num_x[g/2] : num_y[g/2]),
      .den  (det),
      .zero (jctl.singular),
      .quo  (grad[g])
    );
  end

  // carry point status and volume alongside the dividers
  logic                 sb_v_r   [DIV_LAT];
  qsg_ctl_t             sb_ctl_r [DIV_LAT];
  logic signed [DW-1:0] sb_det_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        sb_v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      sb_v_r[0] <= jctl.valid;
      for (int s = 1; s < DIV_LAT; s++) begin
        sb_v_r[s] <= sb_v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_ctl_r[0] <= jctl;
      sb_det_r[0] <= det;
      for (int s = 1; s < DIV_LAT; s++) begin
        sb_ctl_r[s] <= sb_ctl_r[s-1];
        sb_det_r[s] <= sb_det_r[s-1];
      end
    end
  end

  // assemble the result transaction
  always_comb begin
    out_data_nxt.gauss_point  = sb_ctl_r[DIV_LAT-1].point;
    out_data_nxt.grad0_x      = IO_WIDTH'(grad[0]);
    out_data_nxt.grad0_y      = IO_WIDTH'(grad[1]);
    out_data_nxt.grad1_x      = IO_WIDTH'(grad[2]);
    out_data_nxt.grad1_y      = IO_WIDTH'(grad[3]);
    out_data_nxt.grad2_x      = IO_WIDTH'(grad[4]);
    out_data_nxt.grad2_y      = IO_WIDTH'(grad[5]);
    out_data_nxt.grad3_x      = IO_WIDTH'(grad[6]);
    out_data_nxt.grad3_y      = IO_WIDTH'(grad[7]);
    out_data_nxt.point_volume = IO_WIDTH'(sb_det_r[DIV_LAT-1]);
    out_data_nxt.last_point   = (sb_ctl_r[DIV_LAT-1].point == LAST_POINT);
    out_data_nxt.singular     = sb_ctl_r[DIV_LAT-1].singular;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sb_v_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
